// File: src/bgs_pkg.sv
// Shared types and constants of the bar graph split engine.
`default_nettype none

package bgs_pkg;

  // result word kinds
  localparam logic [1:0] KIND_FILL   = 2'd0;
  localparam logic [1:0] KIND_REMAIN = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_W = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_H = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLORS = 3'd7;

  localparam logic signed [15:0] HIGH_LIMIT_RST = 16'sd500;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  typedef struct packed {
    logic              draw;
    logic signed [15:0] split_pos;
    logic signed [15:0] new_pos;
  } bgs_cmd_t;

  typedef struct packed {
    logic              orient;
    logic [7:0]        x;
    logic [7:0]        y;
    logic [7:0]        w;
    logic [7:0]        h;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic [31:0]       colors;
  } bgs_cfg_t;

endpackage

`default_nettype wire

// File: src/bgs_front.sv
// Front end: accepts deltas, updates the position and queues draw commands.
`default_nettype none

module bgs_front import bgs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_delta,
  input  wire logic signed [15:0] low_limit,
  input  wire logic signed [15:0] high_limit,
  input  wire logic               q_full,
  output logic                    q_push,
  output bgs_cmd_t                q_data
);

  logic signed [15:0] pos_r, pos_nxt;
  logic               pend_r, pend_nxt;
  logic signed [16:0] sum;
  logic signed [15:0] sat;

  always_comb begin
    sum = {pos_r[15], pos_r} + {in_delta[15], in_delta};
    if (sum[16] != sum[15]) begin
      sat = sum[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat = sum[15:0];
    end
    // low limit checked first; with inverted limits only values below low get low
    if (sat < low_limit) begin
      pos_nxt = low_limit;
    end else if (sat > high_limit) begin
      pos_nxt = high_limit;
    end else begin
      pos_nxt = sat;
    end
    pend_nxt = (pos_nxt != pos_r);
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.draw      = pend_r;
    q_data.split_pos = pos_r;
    q_data.new_pos   = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      pend_r <= 1'b1;
    end else if (q_push) begin
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/bgs_queue.sv
// Two-entry command queue between front and back.
`default_nettype none

module bgs_queue import bgs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire bgs_cmd_t push_data,
  input  wire logic     pop,
  output bgs_cmd_t      pop_data,
  output logic          full,
  output logic          empty
);

  localparam int CntW = QUEUE_PTR_W + 1;

  bgs_cmd_t                 entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wptr_r, rptr_r;
  logic [CntW-1:0]          cnt_r;

  assign full     = (cnt_r == CntW'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bgs_back.sv
// Back end: computes the split with a restoring divider and emits result words.
`default_nettype none

module bgs_back import bgs_pkg::*; #(
  parameter int COORD_WIDTH = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire bgs_cfg_t cfg,
  input  wire logic     q_empty,
  input  wire bgs_cmd_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [1:0]    out_kind,
  output logic [8:0]    out_x,
  output logic [8:0]    out_y,
  output logic [7:0]    out_width,
  output logic [7:0]    out_height,
  output logic [15:0]   out_color,
  output logic signed [15:0] out_new_position,
  output logic          out_last
);

  localparam logic [7:0] CoordMask =
    (COORD_WIDTH >= 8) ? 8'hff : 8'((1 << COORD_WIDTH) - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_REMAIN = 3'd5;
  localparam logic [2:0] S_REPORT = 3'd6;

  logic [2:0]  state_r, state_nxt;
  bgs_cmd_t    cmd_r;
  logic [7:0]  len_r;
  logic [15:0] off_r, span_r;
  logic [15:0] rem_r;
  logic [7:0]  quo_r;
  logic [2:0]  cnt_r;

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [8:0]  x_r, y_r;
  logic [7:0]  w_r, h_r;
  logic [15:0] color_r;
  logic signed [15:0] npos_r;
  logic        last_r;

  logic [7:0]  xm, ym, wm, hm;
  logic signed [16:0] span17, off17;
  logic [15:0] off_clip, span_use;
  logic [23:0] prod;
  logic [16:0] trial;
  logic        ge;
  logic        load_ok, load;

  assign xm = cfg.x & CoordMask;
  assign ym = cfg.y & CoordMask;
  assign wm = cfg.w & CoordMask;
  assign hm = cfg.h & CoordMask;

  // offset clipped to [0, span]; an empty or inverted span divides zero by one
  always_comb begin
    span17 = {cfg.high[15], cfg.high} - {cfg.low[15], cfg.low};
    off17  = {cmd_r.split_pos[15], cmd_r.split_pos} - {cfg.low[15], cfg.low};
    if (span17 <= 17'sd0) begin
      span_use = 16'd1;
      off_clip = 16'd0;
    end else begin
      span_use = span17[15:0];
      if (off17 < 17'sd0) begin
        off_clip = 16'd0;
      end else if (off17 > span17) begin
        off_clip = span17[15:0];
      end else begin
        off_clip = off17[15:0];
      end
    end
  end

  assign prod  = len_r * off_r;
  assign trial = {rem_r, quo_r[7]};
  assign ge    = (trial >= {1'b0, span_r});

  assign load_ok = !valid_r || out_ready;
  assign q_pop   = (state_r == S_IDLE) && !q_empty;
  assign load    = load_ok &&
                   (state_r == S_FILL || state_r == S_REMAIN || state_r == S_REPORT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (!q_empty) state_nxt = q_data.draw ? S_PREP : S_REPORT;
      S_PREP:   state_nxt = S_MUL;
      S_MUL:    state_nxt = S_DIV;
      S_DIV:    if (cnt_r == 3'd7) state_nxt = S_FILL;
      S_FILL:   if (load_ok) state_nxt = S_REMAIN;
      S_REMAIN: if (load_ok) state_nxt = S_REPORT;
      S_REPORT: if (load_ok) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
    end
    case (state_r)
      S_PREP: begin
        len_r  <= cfg.orient ? hm : wm;
        off_r  <= off_clip;
        span_r <= span_use;
      end
      S_MUL: begin
        // product is below 256 * span, so the high part is already a remainder
        rem_r <= prod[23:8];
        quo_r <= prod[7:0];
        cnt_r <= 3'd0;
      end
      S_DIV: begin
        rem_r <= ge ? 16'(trial - {1'b0, span_r}) : trial[15:0];
        quo_r <= {quo_r[6:0], ge};
        cnt_r <= cnt_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load) begin
      case (state_r)
        S_FILL: begin
          kind_r  <= KIND_FILL;
          x_r     <= {1'b0, xm};
          y_r     <= {1'b0, ym};
          w_r     <= cfg.orient ? wm : quo_r;
          h_r     <= cfg.orient ? quo_r : hm;
          color_r <= cfg.colors[15:0];
          npos_r  <= '0;
          last_r  <= 1'b0;
        end
        S_REMAIN: begin
          kind_r  <= KIND_REMAIN;
          x_r     <= cfg.orient ? {1'b0, xm} : {1'b0, xm} + {1'b0, quo_r};
          y_r     <= cfg.orient ? {1'b0, ym} + {1'b0, quo_r} : {1'b0, ym};
          w_r     <= cfg.orient ? wm : wm - quo_r;
          h_r     <= cfg.orient ? hm - quo_r : hm;
          color_r <= cfg.colors[31:16];
          npos_r  <= '0;
          last_r  <= 1'b0;
        end
        default: begin
          kind_r  <= KIND_REPORT;
          x_r     <= '0;
          y_r     <= '0;
          w_r     <= '0;
          h_r     <= '0;
          color_r <= '0;
          npos_r  <= cmd_r.new_pos;
          last_r  <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_x            = x_r;
  assign out_y            = y_r;
  assign out_width        = w_r;
  assign out_height       = h_r;
  assign out_color        = color_r;
  assign out_new_position = npos_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

// File: src/bar_graph_split_engine.sv
// Top level of the bar graph split engine: configuration registers and wiring.
//
//  channel | direction | handshake              | words
//  in_     | input     | in_valid / in_ready    | one delta per item
//  out_    | output    | out_valid / out_ready  | two rectangles when redraw pends, then a report
//  cfg_    | input     | cfg_valid / cfg_ready  | register index and data, always ready
//
// An item with a pending redraw passes the back end as a pop, a step to clip the offset,
// a multiply, eight restoring divider steps, then three output words.
// An item without redraw is a pop and a report. The divider sets the rate unless out_ready stalls.
// Synchronous active-low reset sets position 0 and redraw pending; no clearing pass.
// The front takes new deltas while the two-entry queue has room; a stalled back fills it.
`default_nettype none

module bar_graph_split_engine import bgs_pkg::*; #(
  parameter int COORD_WIDTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_delta,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic [8:0]              out_x,
  output logic [8:0]              out_y,
  output logic [7:0]              out_width,
  output logic [7:0]              out_height,
  output logic [15:0]             out_color,
  output logic signed [15:0]      out_new_position,
  output logic                    out_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]        cfg_data
);

  bgs_cfg_t cfg_r;
  bgs_cmd_t push_data, pop_data;
  logic     q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.orient <= 1'b0;
      cfg_r.x      <= '0;
      cfg_r.y      <= '0;
      cfg_r.w      <= '0;
      cfg_r.h      <= '0;
      cfg_r.low    <= '0;
      cfg_r.high   <= HIGH_LIMIT_RST;
      cfg_r.colors <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIENT: cfg_r.orient <= cfg_data[0];
        REG_RECT_X: cfg_r.x      <= cfg_data[7:0];
        REG_RECT_Y: cfg_r.y      <= cfg_data[7:0];
        REG_RECT_W: cfg_r.w      <= cfg_data[7:0];
        REG_RECT_H: cfg_r.h      <= cfg_data[7:0];
        REG_LOW:    cfg_r.low    <= cfg_data[15:0];
        REG_HIGH:   cfg_r.high   <= cfg_data[15:0];
        REG_COLORS: cfg_r.colors <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bgs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_delta   (in_delta),
    .low_limit  (cfg_r.low),
    .high_limit (cfg_r.high),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  bgs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  bgs_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_data           (pop_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_width        (out_width),
    .out_height       (out_height),
    .out_color        (out_color),
    .out_new_position (out_new_position),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// File: src/bgs_checker.sv
// Port-level checker of the bar graph split engine and its bind.
`default_nettype none

module bgs_checker import bgs_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic signed [15:0] in_delta,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_kind,
  input wire logic [8:0]         out_x,
  input wire logic [8:0]         out_y,
  input wire logic [7:0]         out_width,
  input wire logic [7:0]         out_height,
  input wire logic [15:0]        out_color,
  input wire logic signed [15:0] out_new_position,
  input wire logic               out_last
);

  // hold an offered delta until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_delta))
    else $error("input word dropped or changed while waiting");

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_x)
      && $stable(out_y) && $stable(out_width) && $stable(out_height)
      && $stable(out_color) && $stable(out_new_position) && $stable(out_last))
    else $error("output word changed while stalled");

  a_report_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REPORT |-> out_last && out_x == '0 && out_y == '0
      && out_width == '0 && out_height == '0 && out_color == '0)
    else $error("malformed report word");

  a_rect_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FILL || out_kind == KIND_REMAIN)
      |-> !out_last && out_new_position == '0)
    else $error("malformed rectangle word");

  // the remainder rectangle follows the filled one directly
  a_fill_then_remain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_FILL |=> !out_valid || out_kind == KIND_REMAIN)
    else $error("filled rectangle not followed by remainder");

endmodule

bind bar_graph_split_engine bgs_checker u_bgs_checker (.*);

`default_nettype wire

// File: sim/tb_bar_graph_split_engine.sv
// Self-checking testbench of the bar graph split engine: random traffic against a predictor.
`timescale 1ns / 100ps

module tb_bar_graph_split_engine;
  import bgs_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 28;

  typedef struct {
    logic [1:0]         kind;
    logic [8:0]         x;
    logic [8:0]         y;
    logic [7:0]         w;
    logic [7:0]         h;
    logic [15:0]        color;
    logic signed [15:0] pos;
    logic               last;
  } bar_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [15:0]   in_delta = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_kind;
  logic [8:0]           out_x;
  logic [8:0]           out_y;
  logic [7:0]           out_width;
  logic [7:0]           out_height;
  logic [15:0]          out_color;
  logic signed [15:0]   out_new_position;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // shadow of the block's registers and state
  bgs_cfg_t           cfg_shadow;
  logic signed [15:0] bar_pos;
  logic               redraw_due;

  logic signed [15:0] delta_q[$];
  bar_word_t          pending_words[$];

  int  fail_count = 0;
  int  sent_count = 0;
  int  word_count = 0;
  int  write_count = 0;
  int  phase_count = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  int  idle_cycles = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;
  bit  stall_request = 1'b0;

  bar_graph_split_engine uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_delta         (in_delta),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_width        (out_width),
    .out_height       (out_height),
    .out_color        (out_color),
    .out_new_position (out_new_position),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // filled length of the bar, offset clipped into the span
  function automatic logic [7:0] split_len(input logic [7:0] length);
    int lo, hi, span, off;
    lo = cfg_shadow.low;
    hi = cfg_shadow.high;
    span = hi - lo;
    off = int'(bar_pos) - lo;
    if (span <= 0) return 8'd0;
    if (off < 0) off = 0;
    if (off > span) off = span;
    return 8'((int'(length) * off) / span);
  endfunction

  // apply one delta: queue the redraw rectangles if due, then the report
  function automatic void advance_bar(input logic signed [15:0] delta);
    bar_word_t  fill, rest, rep;
    logic [7:0] s;
    int         sum;
    fill = '{KIND_FILL, {1'b0, cfg_shadow.x}, {1'b0, cfg_shadow.y}, cfg_shadow.w,
             cfg_shadow.h, cfg_shadow.colors[15:0], 16'sd0, 1'b0};
    rest = '{KIND_REMAIN, {1'b0, cfg_shadow.x}, {1'b0, cfg_shadow.y}, cfg_shadow.w,
             cfg_shadow.h, cfg_shadow.colors[31:16], 16'sd0, 1'b0};
    if (redraw_due) begin
      if (!cfg_shadow.orient) begin
        s = split_len(cfg_shadow.w);
        fill.w = s;
        rest.x = {1'b0, cfg_shadow.x} + {1'b0, s};
        rest.w = cfg_shadow.w - s;
      end else begin
        s = split_len(cfg_shadow.h);
        fill.h = s;
        rest.y = {1'b0, cfg_shadow.y} + {1'b0, s};
        rest.h = cfg_shadow.h - s;
      end
      pending_words.push_back(fill);
      pending_words.push_back(rest);
      redraw_due = 1'b0;
    end
    sum = int'(bar_pos) + int'(delta);
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    if (sum < int'(cfg_shadow.low)) sum = cfg_shadow.low;
    else if (sum > int'(cfg_shadow.high)) sum = cfg_shadow.high;
    if (sum != int'(bar_pos)) begin
      bar_pos = 16'(sum);
      redraw_due = 1'b1;
    end
    rep = '{KIND_REPORT, 9'd0, 9'd0, 8'd0, 8'd0, 16'd0, 16'(sum), 1'b1};
    pending_words.push_back(rep);
  endfunction

  task automatic cmp_field(input string tag, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
    end
  endtask

  // driver: offer queued deltas, predict on each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        advance_bar(in_delta);
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0 || delta_q.size() == 0) begin
          in_valid <= 1'b0;
          if (tx_wait > 0) tx_wait--;
        end else begin
          in_valid <= 1'b1;
          in_delta <= delta_q.pop_front();
          tx_wait = tx_idle_on ? pick_gap() : 0;
        end
      end
    end
  end

  // monitor: check each result word against the oldest prediction
  always @(posedge clk) begin
    bar_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        word_count++;
        if (pending_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, actual kind %0d pos %0d",
                   $time, out_kind, out_new_position);
        end else begin
          want = pending_words.pop_front();
          cmp_field("kind", 16'(want.kind), 16'(out_kind));
          cmp_field("x", 16'(want.x), 16'(out_x));
          cmp_field("y", 16'(want.y), 16'(out_y));
          cmp_field("width", 16'(want.w), 16'(out_width));
          cmp_field("height", 16'(want.h), 16'(out_height));
          cmp_field("color", want.color, out_color);
          cmp_field("new_position", want.pos, out_new_position);
          cmp_field("last", 16'(want.last), 16'(out_last));
        end
      end
      if (stall_request) begin
        rx_wait = HOLD_CYCLES;
        stall_request = 1'b0;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_wait = rx_idle_on ? pick_gap() : 0;
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_ORIENT: cfg_shadow.orient = val[0];
      REG_RECT_X: cfg_shadow.x = val[7:0];
      REG_RECT_Y: cfg_shadow.y = val[7:0];
      REG_RECT_W: cfg_shadow.w = val[7:0];
      REG_RECT_H: cfg_shadow.h = val[7:0];
      REG_LOW:    cfg_shadow.low = val[15:0];
      REG_HIGH:   cfg_shadow.high = val[15:0];
      REG_COLORS: cfg_shadow.colors = val;
      default: ;
    endcase
    write_count++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_bar(input logic orient, input logic [7:0] x, input logic [7:0] y,
                         input logic [7:0] w, input logic [7:0] h, input int lo,
                         input int hi, input logic [31:0] colors);
    write_reg(REG_ORIENT, {31'd0, orient});
    write_reg(REG_RECT_X, {24'd0, x});
    write_reg(REG_RECT_Y, {24'd0, y});
    write_reg(REG_RECT_W, {24'd0, w});
    write_reg(REG_RECT_H, {24'd0, h});
    write_reg(REG_LOW, 32'(lo));
    write_reg(REG_HIGH, 32'(hi));
    write_reg(REG_COLORS, colors);
    phase_count++;
  endtask

  // hold until every queued delta is taken and every word has come back
  task automatic drain();
    do @(negedge clk); while (delta_q.size() != 0 || in_valid || pending_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_delta();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom);
      7: return 16'sd0;
      8: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      9: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      default: return 16'($urandom_range(0, 600) - 300);
    endcase
  endfunction

  initial begin
    int lo, hi;
    logic [31:0] colors;
    cfg_shadow = '{orient: 1'b0, x: 8'd0, y: 8'd0, w: 8'd0, h: 8'd0, low: 16'sd0,
                   high: HIGH_LIMIT_RST, colors: 32'd0};
    bar_pos = 16'sd0;
    redraw_due = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values, clamp at both default limits
    delta_q = '{16'sd0, 16'sd100, 16'sd600, -16'sd1000};
    drain();

    // widest limits and rectangle, sum saturation both ways
    set_bar(1'b0, 8'd255, 8'd255, 8'd255, 8'd255, -32768, 32767, 32'hffff_ffff);
    delta_q = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd0};
    drain();

    // vertical bar, zero span
    set_bar(1'b1, 8'd10, 8'd200, 8'd100, 8'd255, 100, 100, 32'h1234_abcd);
    delta_q = '{16'sd5, -16'sd5, 16'sd0};
    drain();

    // inverted limits: low checked first
    set_bar(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 50, -50, 32'h0000_0000);
    delta_q = '{16'sd10, -16'sd200, 16'sd0};
    drain();

    // position left outside the limits by later rewrites
    set_bar(1'b0, 8'd20, 8'd30, 8'd200, 8'd40, 0, 1000, 32'h5a5a_a5a5);
    delta_q = '{16'sd900};
    drain();
    set_bar(1'b0, 8'd20, 8'd30, 8'd200, 8'd40, -100, 100, 32'h5a5a_a5a5);
    delta_q = '{16'sd0};
    drain();
    set_bar(1'b1, 8'd20, 8'd30, 8'd200, 8'd40, 500, 600, 32'ha5a5_5a5a);
    delta_q = '{16'sd0};
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: begin lo = -32768; hi = 32767; end
        1: begin lo = $urandom_range(0, 600) - 300; hi = lo; end
        2: begin lo = $urandom_range(0, 200); hi = lo - $urandom_range(1, 100); end
        default: begin lo = $urandom_range(0, 2000) - 1000; hi = lo + $urandom_range(1, 1500); end
      endcase
      case ($urandom_range(0, 3))
        0: colors = 32'd0;
        1: colors = 32'hffff_ffff;
        default: colors = $urandom;
      endcase
      set_bar(1'($urandom_range(0, 1)), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
              lo, hi, colors);
      tx_idle_on = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_idle_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      // one phase starves the result side so the input backs up
      if (p == 2) stall_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) delta_q.push_back(pick_delta());
      drain();
    end

    repeat (30) @(posedge clk);
    $display("covered %0d deltas, %0d result words, %0d register writes",
             sent_count, word_count, write_count);
    $display("over %0d register settings incl. full, zero and inverted limits", phase_count);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d words never came", fail_count, pending_words.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
